// File: src/hcb_pkg.sv
// package for the huffman code builder
// holds field widths, parameter defaults, controller states and the leaf record
`timescale 1ns / 1ps
package hcb_pkg;

  localparam int MAX_SYMBOLS_DEF = 64;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam int WEIGHT_W = 16;
  localparam int CODE_W   = 63;
  localparam int LEN_W    = 6;
  localparam int WPL_W    = 28;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SF_TOP0,
    ST_SF_TOP1,
    ST_SF_W,
    ST_SF_CHK,
    ST_SF_K0,
    ST_SF_K1,
    ST_SF_K2,
    ST_SF_K3,
    ST_MG_CHK,
    ST_MG_R0,
    ST_MG_R1,
    ST_MG_R2,
    ST_MG_L0,
    ST_MG_L1,
    ST_MG_L2,
    ST_WK_R0,
    ST_WK_R1,
    ST_WK_POP,
    ST_WK_P1,
    ST_WK_P2,
    ST_WK_PUSH,
    ST_WK_EMIT
  } hcb_state_e;

  typedef enum logic [1:0] {
    PH_BUILD,
    PH_MERGE_R,
    PH_MERGE_L
  } hcb_phase_e;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [CODE_W-1:0]   code;
    logic [LEN_W-1:0]    length;
    logic                dropped;
    logic                is_final;
  } hcb_leaf_t;

endpackage

// File: src/hcb_out_stage.sv
// result register of the huffman code builder with weighted path length accumulator
// depends on hcb_pkg
`timescale 1ns / 1ps
module hcb_out_stage
  import hcb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  hcb_leaf_t           leaf_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [WEIGHT_W-1:0] leaf_weight_o,
  output logic [CODE_W-1:0]   code_bits_o,
  output logic [LEN_W-1:0]    code_length_o,
  output logic [WPL_W-1:0]    total_wpl_o,
  output logic                dropped_input_o,
  output logic                final_leaf_o
);

  logic                      valid_q, valid_d;
  logic [WPL_W-1:0]          acc_q, acc_d;
  logic [WEIGHT_W+LEN_W-1:0] prod;
  logic [WPL_W:0]            sum;
  logic [WPL_W-1:0]          sat;
  hcb_leaf_t                 leaf_q;
  logic [WPL_W-1:0]          wpl_q;

  assign prod = (WEIGHT_W+LEN_W)'(leaf_i.weight) * (WEIGHT_W+LEN_W)'(leaf_i.length);
  assign sum  = {1'b0, acc_q} + (WPL_W+1)'(prod);
  assign sat  = sum[WPL_W] ? '1 : sum[WPL_W-1:0];

  always_comb begin
    valid_d = valid_q;
    acc_d   = acc_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
      acc_d   = leaf_i.is_final ? '0 : sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      acc_q   <= '0;
    end else begin
      valid_q <= valid_d;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      leaf_q <= leaf_i;
      wpl_q  <= leaf_i.is_final ? sat : '0;
    end
  end

  assign out_valid_o     = valid_q;
  assign leaf_weight_o   = leaf_q.weight;
  assign code_bits_o     = leaf_q.code;
  assign code_length_o   = leaf_q.length;
  assign total_wpl_o     = wpl_q;
  assign dropped_input_o = leaf_q.dropped;
  assign final_leaf_o    = leaf_q.is_final;

endmodule

// File: src/huffman_code_builder_unit.sv
// huffman code builder top level: weight loading, heap build, merges and tree walk
// depends on hcb_pkg and hcb_out_stage
//
//  channel | direction | handshake               | payload
//  input   | in        | in_valid_i / in_ready_o | weight_i, last_weight_i
//  result  | out       | out_valid_o/out_ready_i | leaf_weight_o .. final_leaf_o
//
// a weight that is not marked last is taken while idle; the block is ready again in the next cycle
// the last weight starts a build: at each heap level visited, both children are read
// from heap memory and then their weights from node memory
// the walk pops a stack entry, reads its node, then pushes its children or emits a leaf
// reset clears the load counter, overflow flag and controller; memories are not cleared
// a stalled result holds the walk in place until the result register is free
`timescale 1ns / 1ps
module huffman_code_builder_unit
  import hcb_pkg::*;
#(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [WEIGHT_W-1:0] weight_i,
  input  logic                last_weight_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [WEIGHT_W-1:0] leaf_weight_o,
  output logic [CODE_W-1:0]   code_bits_o,
  output logic [LEN_W-1:0]    code_length_o,
  output logic [WPL_W-1:0]    total_wpl_o,
  output logic                dropped_input_o,
  output logic                final_leaf_o
);

  localparam int LW    = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
  localparam int HW    = $clog2(MAX_SYMBOLS);
  localparam int CW    = HW + 1;
  localparam int KW    = HW + 2;
  localparam int NW    = LW + HW;
  localparam int IW    = $clog2(2 * MAX_SYMBOLS);
  localparam int NODES = 2 * MAX_SYMBOLS - 1;
  localparam int NDW   = NW + 2 * IW;
  localparam int SW    = IW + LEN_W + CODE_W;
  localparam logic [IW-1:0] NO_CHILD = '1;

  hcb_state_e state_q, state_d;
  hcb_phase_e phase_q, phase_d;

  logic [CW-1:0]     cnt_q, cnt_d, size_q, size_d, sp_q, sp_d, n_new;
  logic              ovf_q, ovf_d;
  logic [IW-1:0]     next_q, next_d;
  logic [HW-1:0]     i_q, i_d, top_q, top_d;
  logic [KW-1:0]     kid_q, kid_d;
  logic [IW-1:0]     cur_node_q, cur_node_d, a_node_q, a_node_d, b_node_q, b_node_d;
  logic [IW-1:0]     right_q, right_d, left_q, left_d;
  logic [NW-1:0]     cur_w_q, cur_w_d, a_w_q, a_w_d, right_w_q, right_w_d, leaf_w_q, leaf_w_d;
  logic [LEN_W-1:0]  e_depth_q, e_depth_d;
  logic [CODE_W-1:0] e_code_q, e_code_d;

  logic [NDW-1:0] node_mem [NODES];
  logic [IW-1:0]  heap_mem [MAX_SYMBOLS];
  logic [SW-1:0]  stack_mem [MAX_SYMBOLS];
  logic [NDW-1:0] node_rd_q;
  logic [IW-1:0]  heap_rd_q;
  logic [SW-1:0]  stack_rd_q;

  logic           node_we, heap_we, stack_we;
  logic [IW-1:0]  node_waddr, node_raddr;
  logic [NDW-1:0] node_wdata;
  logic [HW-1:0]  heap_waddr, heap_raddr, stack_waddr, stack_raddr;
  logic [IW-1:0]  heap_wdata;
  logic [SW-1:0]  stack_wdata;

  logic [NW-1:0]  nd_w;
  logic [IW-1:0]  nd_l, nd_r;
  logic           in_acc, store_ok, b_ok, take_b, move, sift_done, out_free, out_load;
  logic [IW-1:0]  pick_node;
  logic [NW-1:0]  pick_w;
  logic [KW-1:0]  size_k;
  hcb_leaf_t      leaf;
  hcb_state_e     ret_state;

  assign nd_w = node_rd_q[2*IW +: NW];
  assign nd_l = node_rd_q[IW +: IW];
  assign nd_r = node_rd_q[0 +: IW];

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign store_ok   = (cnt_q < CW'(MAX_SYMBOLS));
  assign n_new      = store_ok ? cnt_q + CW'(1) : cnt_q;
  assign size_k     = KW'(size_q);
  assign out_free   = !out_valid_o || out_ready_i;

  // sift compare: right child only when strictly lighter, move only when strictly lighter
  always_comb begin
    b_ok      = (kid_q + KW'(1)) < size_k;
    take_b    = b_ok && (nd_w < a_w_q);
    pick_node = take_b ? b_node_q : a_node_q;
    pick_w    = take_b ? nd_w : a_w_q;
    move      = pick_w < cur_w_q;
    sift_done = ((state_q == ST_SF_CHK) && !(kid_q < size_k)) ||
                ((state_q == ST_SF_K3) && !move);
  end

  always_comb begin
    unique case (phase_q)
      PH_BUILD:   ret_state = (i_q == '0) ? ST_MG_CHK : ST_SF_TOP0;
      PH_MERGE_R: ret_state = ST_MG_L0;
      PH_MERGE_L: ret_state = ST_MG_CHK;
      default:    ret_state = ST_MG_CHK;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && last_weight_i) begin
          state_d = (n_new > CW'(1)) ? ST_SF_TOP0 : ST_MG_CHK;
        end
      end
      ST_SF_TOP0: state_d = ST_SF_TOP1;
      ST_SF_TOP1: state_d = ST_SF_W;
      ST_SF_W:    state_d = ST_SF_CHK;
      ST_SF_CHK:  state_d = (kid_q < size_k) ? ST_SF_K0 : ret_state;
      ST_SF_K0:   state_d = ST_SF_K1;
      ST_SF_K1:   state_d = ST_SF_K2;
      ST_SF_K2:   state_d = ST_SF_K3;
      ST_SF_K3:   state_d = move ? ST_SF_CHK : ret_state;
      ST_MG_CHK:  state_d = (size_q > CW'(1)) ? ST_MG_R0 : ST_WK_R0;
      ST_MG_R0:   state_d = ST_MG_R1;
      ST_MG_R1:   state_d = ST_MG_R2;
      ST_MG_R2:   state_d = ST_SF_W;
      ST_MG_L0:   state_d = ST_MG_L1;
      ST_MG_L1:   state_d = ST_MG_L2;
      ST_MG_L2:   state_d = ST_SF_CHK;
      ST_WK_R0:   state_d = ST_WK_R1;
      ST_WK_R1:   state_d = ST_WK_POP;
      ST_WK_POP:  state_d = ST_WK_P1;
      ST_WK_P1:   state_d = ST_WK_P2;
      ST_WK_P2:   state_d = (nd_l == NO_CHILD) ? ST_WK_EMIT : ST_WK_PUSH;
      ST_WK_PUSH: state_d = ST_WK_POP;
      ST_WK_EMIT: begin
        if (out_free) begin
          state_d = (sp_q == '0) ? ST_IDLE : ST_WK_POP;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    size_d     = size_q;
    sp_d       = sp_q;
    next_d     = next_q;
    i_d        = i_q;
    top_d      = top_q;
    kid_d      = kid_q;
    cur_node_d = cur_node_q;
    cur_w_d    = cur_w_q;
    a_node_d   = a_node_q;
    a_w_d      = a_w_q;
    b_node_d   = b_node_q;
    right_d    = right_q;
    right_w_d  = right_w_q;
    left_d     = left_q;
    e_depth_d  = e_depth_q;
    e_code_d   = e_code_q;
    leaf_w_d   = leaf_w_q;

    node_we     = 1'b0;
    node_waddr  = next_q;
    node_wdata  = '0;
    node_raddr  = cur_node_q;
    heap_we     = 1'b0;
    heap_waddr  = top_q;
    heap_wdata  = cur_node_q;
    heap_raddr  = top_q;
    stack_we    = 1'b0;
    stack_waddr = sp_q[HW-1:0];
    stack_wdata = '0;
    stack_raddr = sp_q[HW-1:0];
    out_load    = 1'b0;

    leaf.weight   = WEIGHT_W'(leaf_w_q);
    leaf.code     = e_code_q;
    leaf.length   = e_depth_q;
    leaf.dropped  = ovf_q;
    leaf.is_final = (sp_q == '0);

    if (sift_done) begin
      heap_we = 1'b1;
      if (phase_q == PH_BUILD && i_q != '0) begin
        i_d   = i_q - HW'(1);
        top_d = i_q - HW'(1);
        kid_d = {1'b0, i_q - HW'(1), 1'b1};
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (store_ok) begin
            node_we    = 1'b1;
            node_waddr = IW'(cnt_q);
            node_wdata = {NW'(weight_i[LW-1:0]), NO_CHILD, NO_CHILD};
            heap_we    = 1'b1;
            heap_waddr = cnt_q[HW-1:0];
            heap_wdata = IW'(cnt_q);
            cnt_d      = n_new;
          end else begin
            ovf_d = 1'b1;
          end
          if (last_weight_i) begin
            phase_d = PH_BUILD;
            size_d  = n_new;
            next_d  = IW'(n_new);
            i_d     = HW'((n_new - CW'(2)) >> 1);
            top_d   = HW'((n_new - CW'(2)) >> 1);
            kid_d   = {1'b0, HW'((n_new - CW'(2)) >> 1), 1'b1};
          end
        end
      end
      ST_SF_TOP0: heap_raddr = top_q;
      ST_SF_TOP1: begin
        cur_node_d = heap_rd_q;
        node_raddr = heap_rd_q;
      end
      ST_SF_W: cur_w_d = nd_w;
      ST_SF_K0: heap_raddr = kid_q[HW-1:0];
      ST_SF_K1: begin
        a_node_d   = heap_rd_q;
        node_raddr = heap_rd_q;
        heap_raddr = HW'(kid_q + KW'(1));
      end
      ST_SF_K2: begin
        a_w_d      = nd_w;
        b_node_d   = heap_rd_q;
        node_raddr = heap_rd_q;
      end
      ST_SF_K3: begin
        if (move) begin
          heap_we    = 1'b1;
          heap_wdata = pick_node;
          top_d      = take_b ? HW'(kid_q + KW'(1)) : kid_q[HW-1:0];
          kid_d      = take_b ? {1'b0, kid_q[HW-1:0] + HW'(1), 1'b1} :
                                {1'b0, kid_q[HW-1:0], 1'b1};
        end
      end
      ST_MG_R0: heap_raddr = '0;
      ST_MG_R1: begin
        right_d    = heap_rd_q;
        node_raddr = heap_rd_q;
        heap_raddr = HW'(size_q - CW'(1));
      end
      ST_MG_R2: begin
        right_w_d  = nd_w;
        cur_node_d = heap_rd_q;
        node_raddr = heap_rd_q;
        size_d     = size_q - CW'(1);
        phase_d    = PH_MERGE_R;
        top_d      = '0;
        kid_d      = KW'(1);
      end
      ST_MG_L0: heap_raddr = '0;
      ST_MG_L1: begin
        left_d     = heap_rd_q;
        node_raddr = heap_rd_q;
      end
      ST_MG_L2: begin
        node_we    = 1'b1;
        node_waddr = next_q;
        node_wdata = {nd_w + right_w_q, left_q, right_q};
        cur_node_d = next_q;
        cur_w_d    = nd_w + right_w_q;
        next_d     = next_q + IW'(1);
        phase_d    = PH_MERGE_L;
        top_d      = '0;
        kid_d      = KW'(1);
      end
      ST_WK_R0: heap_raddr = '0;
      ST_WK_R1: begin
        stack_we    = 1'b1;
        stack_waddr = '0;
        stack_wdata = {heap_rd_q, LEN_W'(0), CODE_W'(0)};
        sp_d        = CW'(1);
      end
      ST_WK_POP: begin
        stack_raddr = HW'(sp_q - CW'(1));
        sp_d        = sp_q - CW'(1);
      end
      ST_WK_P1: begin
        e_depth_d  = stack_rd_q[CODE_W +: LEN_W];
        e_code_d   = stack_rd_q[0 +: CODE_W];
        node_raddr = stack_rd_q[LEN_W+CODE_W +: IW];
      end
      ST_WK_P2: begin
        leaf_w_d = nd_w;
        left_d   = nd_l;
        if (nd_l != NO_CHILD) begin
          stack_we    = 1'b1;
          stack_wdata = {nd_r, e_depth_q + LEN_W'(1), {e_code_q[CODE_W-2:0], 1'b1}};
          sp_d        = sp_q + CW'(1);
        end
      end
      ST_WK_PUSH: begin
        stack_we    = 1'b1;
        stack_wdata = {left_q, e_depth_q + LEN_W'(1), {e_code_q[CODE_W-2:0], 1'b0}};
        sp_d        = sp_q + CW'(1);
      end
      ST_WK_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (sp_q == '0) begin
            cnt_d = '0;
            ovf_d = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_BUILD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      sp_q    <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      sp_q    <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q     <= size_d;
    next_q     <= next_d;
    i_q        <= i_d;
    top_q      <= top_d;
    kid_q      <= kid_d;
    cur_node_q <= cur_node_d;
    cur_w_q    <= cur_w_d;
    a_node_q   <= a_node_d;
    a_w_q      <= a_w_d;
    b_node_q   <= b_node_d;
    right_q    <= right_d;
    right_w_q  <= right_w_d;
    left_q     <= left_d;
    e_depth_q  <= e_depth_d;
    e_code_q   <= e_code_d;
    leaf_w_q   <= leaf_w_d;
  end

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_rd_q <= node_mem[node_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (heap_we) begin
      heap_mem[heap_waddr] <= heap_wdata;
    end
    heap_rd_q <= heap_mem[heap_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wdata;
    end
    stack_rd_q <= stack_mem[stack_raddr];
  end

  hcb_out_stage u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (out_load),
    .leaf_i         (leaf),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .leaf_weight_o  (leaf_weight_o),
    .code_bits_o    (code_bits_o),
    .code_length_o  (code_length_o),
    .total_wpl_o    (total_wpl_o),
    .dropped_input_o(dropped_input_o),
    .final_leaf_o   (final_leaf_o)
  );

endmodule
